### hw/rtl/cmes_pkg.sv
`default_nettype none

package cmes_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * Q_W;
  localparam int CNT_W     = 7;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int DEPTH_DEF = 64;

  localparam logic [Q_W-1:0]    ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PROD_W-1:0] HALF_P = PROD_W'(ONE_Q >> 1);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;
  localparam int FILT_LSB    = 0;
  localparam int MED_LSB     = Q_W;
  localparam int STORED_LSB  = 2 * Q_W;
  localparam int FILL_LSB    = 3 * Q_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * Q_W - CNT_W;
  localparam int IN_PAD_W    = IN_TDATA_W - Q_W;

  localparam logic [MODE_W-1:0] MODE_RAW        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EMA_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EMA_MEDIAN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIAN_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ENABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MIN_FILL = 3'd5;

  localparam logic [MODE_W-1:0] FILTER_MODE_RST    = MODE_RAW;
  localparam logic [Q_W-1:0]    EMA_WEIGHT_RST     = 17'd58982;
  localparam logic [CNT_W-1:0]  MEDIAN_COUNT_RST   = 7'd5;
  localparam logic              CLAMP_ENABLE_RST   = 1'b0;
  localparam logic [Q_W-1:0]    CLAMP_STEP_RST     = 17'd6554;
  localparam logic [CNT_W-1:0]  CLAMP_MIN_FILL_RST = 7'd10;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] len;
  } med_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] value;
  } med_rsp_t;

  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] weight;
    logic [Q_W-1:0] avg;
    logic [Q_W-1:0] x;
  } ema_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] value;
  } ema_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/cmes_ram.sv
`default_nettype none

module cmes_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cmes_median.sv
`default_nettype none

module cmes_median import cmes_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire med_req_t                 req,
  input  wire logic [$clog2(DEPTH)-1:0] head,
  output logic                          rd_en,
  output logic      [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic [Q_W-1:0]           rd_data,
  output med_rsp_t                      rsp
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BIT_W  = $clog2(Q_W);

  logic              busy_r;
  logic              dv_r;
  logic              done_r;
  logic [BIT_W-1:0]  bit_r;
  logic [CNT_W-1:0]  len_r;
  logic [CNT_W-1:0]  issue_r;
  logic [CNT_W-1:0]  tally_r;
  logic [CNT_W-1:0]  cnt_lo_r;
  logic [CNT_W-1:0]  cnt_hi_r;
  logic [CNT_W-1:0]  k_lo_r;
  logic [CNT_W-1:0]  k_hi_r;
  logic [Q_W-1:0]    p_lo_r;
  logic [Q_W-1:0]    p_hi_r;
  logic [Q_W-1:0]    val_r;
  logic [ADDR_W-1:0] head_r;
  logic [ADDR_W-1:0] addr_r;

  logic [Q_W-1:0]    hmask;
  logic [Q_W-1:0]    bsel;
  logic              hit_lo;
  logic              hit_hi;
  logic [CNT_W-1:0]  cnt_lo_nxt;
  logic [CNT_W-1:0]  cnt_hi_nxt;
  logic              pass_end;
  logic [Q_W-1:0]    p_lo_nxt;
  logic [Q_W-1:0]    p_hi_nxt;
  logic [CNT_W-1:0]  k_lo_nxt;
  logic [CNT_W-1:0]  k_hi_nxt;
  logic [Q_W:0]      mid_sum;
  logic [ADDR_W-1:0] addr_dec;

  // radix select: one value bit per pass over the window, msb first
  always_comb begin
    hmask      = ({Q_W{1'b1}} << bit_r) << 1;
    bsel       = {{(Q_W-1){1'b0}}, 1'b1} << bit_r;
    hit_lo     = dv_r && (((rd_data ^ p_lo_r) & hmask) == '0) && ((rd_data & bsel) == '0);
    hit_hi     = dv_r && (((rd_data ^ p_hi_r) & hmask) == '0) && ((rd_data & bsel) == '0);
    cnt_lo_nxt = cnt_lo_r + CNT_W'(hit_lo);
    cnt_hi_nxt = cnt_hi_r + CNT_W'(hit_hi);
    pass_end   = dv_r && (tally_r == len_r - CNT_W'(1));
    if (k_lo_r < cnt_lo_nxt) begin
      p_lo_nxt = p_lo_r;
      k_lo_nxt = k_lo_r;
    end else begin
      p_lo_nxt = p_lo_r | bsel;
      k_lo_nxt = k_lo_r - cnt_lo_nxt;
    end
    if (k_hi_r < cnt_hi_nxt) begin
      p_hi_nxt = p_hi_r;
      k_hi_nxt = k_hi_r;
    end else begin
      p_hi_nxt = p_hi_r | bsel;
      k_hi_nxt = k_hi_r - cnt_hi_nxt;
    end
    mid_sum  = {1'b0, p_lo_nxt} + {1'b0, p_hi_nxt} + {{Q_W{1'b0}}, 1'b1};
    addr_dec = (addr_r == '0) ? ADDR_W'(DEPTH - 1) : addr_r - ADDR_W'(1);
  end

  assign rd_en     = busy_r && (issue_r != len_r);
  assign rd_addr   = addr_r;
  assign rsp.done  = done_r;
  assign rsp.value = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      dv_r     <= 1'b0;
      done_r   <= 1'b0;
      bit_r    <= '0;
      len_r    <= '0;
      issue_r  <= '0;
      tally_r  <= '0;
      cnt_lo_r <= '0;
      cnt_hi_r <= '0;
      k_lo_r   <= '0;
      k_hi_r   <= '0;
      p_lo_r   <= '0;
      p_hi_r   <= '0;
      val_r    <= '0;
      head_r   <= '0;
      addr_r   <= '0;
    end else begin
      done_r <= busy_r && pass_end && (bit_r == '0);
      dv_r   <= rd_en;
      if (req.start) begin
        busy_r   <= 1'b1;
        len_r    <= req.len;
        head_r   <= head;
        addr_r   <= head;
        issue_r  <= '0;
        tally_r  <= '0;
        cnt_lo_r <= '0;
        cnt_hi_r <= '0;
        p_lo_r   <= '0;
        p_hi_r   <= '0;
        bit_r    <= BIT_W'(Q_W - 1);
        k_hi_r   <= req.len >> 1;
        if (req.len[0]) begin
          k_lo_r <= req.len >> 1;
        end else begin
          k_lo_r <= (req.len >> 1) - CNT_W'(1);
        end
      end else if (busy_r) begin
        if (rd_en) begin
          issue_r <= issue_r + CNT_W'(1);
          addr_r  <= addr_dec;
        end
        if (dv_r && !pass_end) begin
          tally_r  <= tally_r + CNT_W'(1);
          cnt_lo_r <= cnt_lo_nxt;
          cnt_hi_r <= cnt_hi_nxt;
        end
        if (pass_end) begin
          p_lo_r   <= p_lo_nxt;
          p_hi_r   <= p_hi_nxt;
          k_lo_r   <= k_lo_nxt;
          k_hi_r   <= k_hi_nxt;
          cnt_lo_r <= '0;
          cnt_hi_r <= '0;
          tally_r  <= '0;
          issue_r  <= '0;
          addr_r   <= head_r;
          if (bit_r == '0) begin
            busy_r <= 1'b0;
            val_r  <= mid_sum[Q_W:1];
          end else begin
            bit_r <= bit_r - BIT_W'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cmes_ema.sv
`default_nettype none

module cmes_ema import cmes_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ema_req_t req,
  output ema_rsp_t      rsp
);

  typedef enum logic [1:0] {E_IDLE, E_OLD, E_NEW, E_FIN} ema_state_t;

  ema_state_t        state_r;
  logic [Q_W-1:0]    w_r;
  logic [Q_W-1:0]    avg_r;
  logic [Q_W-1:0]    x_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] sum_r;

  logic [Q_W-1:0]    mul_a;
  logic [Q_W-1:0]    mul_b;
  logic [PROD_W-1:0] mul_p;

  // one multiplier, shared between the old-average and new-input terms
  always_comb begin
    if (state_r == E_NEW) begin
      mul_a = ONE_Q - w_r;
      mul_b = x_r;
    end else begin
      mul_a = w_r;
      mul_b = avg_r;
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign rsp.done  = (state_r == E_FIN);
  assign rsp.value = sum_r[FRAC_BITS +: Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      w_r     <= '0;
      avg_r   <= '0;
      x_r     <= '0;
      prod_r  <= '0;
      sum_r   <= '0;
    end else begin
      unique case (state_r)
        E_IDLE: begin
          if (req.start) begin
            w_r     <= req.weight;
            avg_r   <= req.avg;
            x_r     <= req.x;
            state_r <= E_OLD;
          end
        end
        E_OLD: begin
          prod_r  <= mul_p;
          state_r <= E_NEW;
        end
        E_NEW: begin
          sum_r   <= prod_r + mul_p + HALF_P;
          state_r <= E_FIN;
        end
        E_FIN: begin
          state_r <= E_IDLE;
        end
        default: begin
          state_r <= E_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/clamped_median_ema_smoother.sv
// channel   dir  handshake              payload
// in_       in   in_tvalid/in_tready    tdata: sample; tuser: cmd
// out_      out  out_tvalid/out_tready  tdata: filtered, median, stored_sample, fill_count;
//                                       tuser: was_clamped
// cfg_      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// clear request: goes straight to ST_DONE, which loads the result into the output register
// push request: the fsm steps through ST_PREV, ST_MED and ST_BLEND, plus ST_EMA with averaging,
// then ST_DONE; L = min(median_count, fill); each of the 17 value bits costs one read per element;
// L < 2 skips the select and ST_MED
// rst_n is synchronous; the window ram is not cleared, the fill count bounds every read
// one request in flight; a full output register holds the fsm in its last state until drained
`default_nettype none

module clamped_median_ema_smoother import cmes_pkg::*; #(
  parameter int WINDOW_DEPTH = DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // sample[16:0], zero pad
  input  wire logic [0:0]             in_tuser,   // cmd
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // filtered, median, stored_sample,
                                                  // fill_count, zero pad
  output logic      [0:0]             out_tuser,  // was_clamped
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [Q_W-1:0]         cfg_data
);

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREV, ST_MED, ST_BLEND, ST_EMA, ST_DONE
  } state_t;

  state_t            state_r;
  logic [MODE_W-1:0] mode_r;
  logic [Q_W-1:0]    weight_r;
  logic [CNT_W-1:0]  mcount_r;
  logic              clamp_en_r;
  logic [Q_W-1:0]    step_r;
  logic [CNT_W-1:0]  min_fill_r;

  logic [ADDR_W-1:0] head_r;
  logic [FILL_W-1:0] fill_r;
  logic [Q_W-1:0]    avg_r;
  logic              seeded_r;
  logic [Q_W-1:0]    samp_r;
  logic [Q_W-1:0]    stored_r;
  logic [Q_W-1:0]    med_r;
  logic [Q_W-1:0]    filt_r;
  logic              clamped_r;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;

  logic              in_acc;
  logic [Q_W-1:0]    in_sample;
  logic [Q_W-1:0]    prev;
  logic              clamp_on;
  logic [Q_W-1:0]    delta;
  logic [Q_W:0]      up_sum;
  logic [Q_W-1:0]    stored_c;
  logic              clamped_c;
  logic [FILL_W-1:0] fill_inc;
  logic [ADDR_W-1:0] head_inc;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W-1:0]  len_c;
  logic [Q_W-1:0]    w_sat;
  logic              blend_on;

  med_req_t          med_req;
  med_rsp_t          med_rsp;
  ema_req_t          ema_req;
  ema_rsp_t          ema_rsp;
  logic              med_rd_en;
  logic [ADDR_W-1:0] med_rd_addr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;

  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign cfg_ready = rst_n;
  assign in_acc    = in_tvalid && in_tready;
  assign in_sample = (in_tdata[Q_W-1:0] > ONE_Q) ? ONE_Q : in_tdata[Q_W-1:0];

  always_comb begin
    clamp_on  = clamp_en_r && seeded_r && (CMP_W'(fill_r) >= CMP_W'(min_fill_r));
    delta     = (samp_r >= prev) ? samp_r - prev : prev - samp_r;
    up_sum    = {1'b0, prev} + {1'b0, step_r};
    stored_c  = samp_r;
    clamped_c = 1'b0;
    if (clamp_on && (delta > step_r)) begin
      clamped_c = 1'b1;
      if (samp_r >= prev) begin
        stored_c = (up_sum > {1'b0, ONE_Q}) ? ONE_Q : up_sum[Q_W-1:0];
      end else begin
        stored_c = (prev > step_r) ? prev - step_r : '0;
      end
    end
    fill_inc = (fill_r == FILL_W'(WINDOW_DEPTH)) ? fill_r : fill_r + FILL_W'(1);
    head_inc = (head_r == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : head_r + ADDR_W'(1);
    cnt_eff  = (mcount_r == '0) ? CNT_W'(1) : mcount_r;
    len_c    = (CMP_W'(cnt_eff) > CMP_W'(fill_inc)) ? CNT_W'(fill_inc) : cnt_eff;
    w_sat    = (weight_r > ONE_Q) ? ONE_Q : weight_r;
    blend_on = (mode_r == MODE_EMA_SAMPLE) || (mode_r == MODE_EMA_MEDIAN);
  end

  assign med_req.start  = (state_r == ST_PREV) && (len_c >= CNT_W'(2));
  assign med_req.len    = len_c;
  assign ema_req.start  = (state_r == ST_BLEND) && blend_on;
  assign ema_req.weight = w_sat;
  assign ema_req.avg    = avg_r;
  assign ema_req.x      = (mode_r == MODE_EMA_SAMPLE) ? stored_r : med_r;

  assign ram_re    = (in_acc && !in_tuser[0]) || med_rd_en;
  assign ram_raddr = med_rd_en ? med_rd_addr : head_r;

  cmes_ram #(
    .WIDTH (Q_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (state_r == ST_PREV),
    .waddr (head_inc),
    .wdata (stored_c),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (prev)
  );

  cmes_median #(
    .DEPTH (WINDOW_DEPTH)
  ) u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (med_req),
    .head    (head_inc),
    .rd_en   (med_rd_en),
    .rd_addr (med_rd_addr),
    .rd_data (prev),
    .rsp     (med_rsp)
  );

  cmes_ema u_ema (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ema_req),
    .rsp   (ema_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= FILTER_MODE_RST;
      weight_r   <= EMA_WEIGHT_RST;
      mcount_r   <= MEDIAN_COUNT_RST;
      clamp_en_r <= CLAMP_ENABLE_RST;
      step_r     <= CLAMP_STEP_RST;
      min_fill_r <= CLAMP_MIN_FILL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FILTER_MODE:    mode_r     <= cfg_data[MODE_W-1:0];
        REG_EMA_WEIGHT:     weight_r   <= cfg_data;
        REG_MEDIAN_COUNT:   mcount_r   <= cfg_data[CNT_W-1:0];
        REG_CLAMP_ENABLE:   clamp_en_r <= cfg_data[0];
        REG_CLAMP_STEP:     step_r     <= cfg_data;
        REG_CLAMP_MIN_FILL: min_fill_r <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      fill_r       <= '0;
      avg_r        <= '0;
      seeded_r     <= 1'b0;
      samp_r       <= '0;
      stored_r     <= '0;
      med_r        <= '0;
      filt_r       <= '0;
      clamped_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
      out_tuser_r  <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser[0]) begin
              fill_r    <= '0;
              avg_r     <= '0;
              seeded_r  <= 1'b0;
              stored_r  <= '0;
              med_r     <= '0;
              filt_r    <= '0;
              clamped_r <= 1'b0;
              state_r   <= ST_DONE;
            end else begin
              samp_r  <= in_sample;
              state_r <= ST_PREV;
            end
          end
        end
        ST_PREV: begin
          stored_r  <= stored_c;
          clamped_r <= clamped_c;
          head_r    <= head_inc;
          fill_r    <= fill_inc;
          if (!seeded_r) begin
            avg_r <= stored_c;
          end
          if (len_c >= CNT_W'(2)) begin
            state_r <= ST_MED;
          end else begin
            med_r   <= stored_c;
            state_r <= ST_BLEND;
          end
        end
        ST_MED: begin
          if (med_rsp.done) begin
            med_r   <= med_rsp.value;
            state_r <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          if (blend_on) begin
            state_r <= ST_EMA;
          end else begin
            filt_r  <= stored_r;
            state_r <= ST_DONE;
          end
        end
        ST_EMA: begin
          if (ema_rsp.done) begin
            avg_r    <= ema_rsp.value;
            seeded_r <= 1'b1;
            filt_r   <= ema_rsp.value;
            state_r  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {{OUT_PAD_W{1'b0}}, CNT_W'(fill_r), stored_r, med_r, filt_r};
            out_tuser_r  <= clamped_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

endmodule

`default_nettype wire

### hw/rtl/cmes_checker.sv
`default_nettype none

module cmes_checker import cmes_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [0:0]             out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in flight");

  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[FILT_LSB +: Q_W] <= ONE_Q) &&
                   (out_tdata[MED_LSB +: Q_W] <= ONE_Q) &&
                   (out_tdata[STORED_LSB +: Q_W] <= ONE_Q))
    else $error("result value above one");

endmodule

bind clamped_median_ema_smoother cmes_checker u_cmes_checker (.*);

`default_nettype wire

### tb/clamped_median_ema_smoother_tb.sv
module clamped_median_ema_smoother_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmes_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 1200;
  localparam int N_PHASE        = 20;
  localparam int PHASE_ITEMS    = 35;
  localparam int N_DIR          = 41;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [Q_W-1:0]   filtered;
    logic [Q_W-1:0]   median;
    logic [Q_W-1:0]   stored;
    logic             clamped;
    logic [CNT_W-1:0] fill;
  } smooth_res_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 cmd;
    logic [Q_W-1:0]       value;
    logic                 typed;
    smooth_res_t          res;
  } dir_row_t;

  localparam smooth_res_t NO_RES = '0;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_CLEAR, 17'd0,      1'b1, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd0,      1'b1,
      '{17'd0, 17'd0, 17'd0, 1'b0, 7'd1}},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd65536,  1'b1,
      '{17'd65536, 17'd32768, 17'd65536, 1'b0, 7'd2}},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd131071, 1'b1,
      '{17'd65536, 17'd65536, 17'd65536, 1'b0, 7'd3}},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd12345,  1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_CLEAR, 17'd0,      1'b1, NO_RES},
    '{ROW_CFG,  REG_FILTER_MODE,    CMD_PUSH,  17'(MODE_EMA_SAMPLE), 1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd40000,  1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd50000,  1'b0, NO_RES},
    '{ROW_CFG,  REG_EMA_WEIGHT,     CMD_PUSH,  17'd65536,  1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd0,      1'b0, NO_RES},
    '{ROW_CFG,  REG_EMA_WEIGHT,     CMD_PUSH,  17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd20000,  1'b0, NO_RES},
    '{ROW_CFG,  REG_EMA_WEIGHT,     CMD_PUSH,  17'd131071, 1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd60000,  1'b0, NO_RES},
    '{ROW_CFG,  REG_FILTER_MODE,    CMD_PUSH,  17'(MODE_EMA_MEDIAN), 1'b0, NO_RES},
    '{ROW_CFG,  REG_EMA_WEIGHT,     CMD_PUSH,  17'd32768,  1'b0, NO_RES},
    '{ROW_CFG,  REG_MEDIAN_COUNT,   CMD_PUSH,  17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd30000,  1'b0, NO_RES},
    '{ROW_CFG,  REG_MEDIAN_COUNT,   CMD_PUSH,  17'd64,     1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd1,      1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd65535,  1'b0, NO_RES},
    '{ROW_CFG,  REG_CLAMP_STEP,     CMD_PUSH,  17'd1000,   1'b0, NO_RES},
    '{ROW_CFG,  REG_CLAMP_MIN_FILL, CMD_PUSH,  17'd0,      1'b0, NO_RES},
    '{ROW_CFG,  REG_CLAMP_ENABLE,   CMD_PUSH,  17'd1,      1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd65536,  1'b0, NO_RES},
    '{ROW_CFG,  REG_CLAMP_STEP,     CMD_PUSH,  17'd65536,  1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd0,      1'b0, NO_RES},
    '{ROW_CFG,  REG_CLAMP_STEP,     CMD_PUSH,  17'd131071, 1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd65536,  1'b0, NO_RES},
    '{ROW_CFG,  REG_CLAMP_STEP,     CMD_PUSH,  17'd0,      1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd7,      1'b0, NO_RES},
    '{ROW_CFG,  REG_CLAMP_MIN_FILL, CMD_PUSH,  17'd127,    1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd65536,  1'b0, NO_RES},
    '{ROW_CFG,  REG_FILTER_MODE,    CMD_PUSH,  17'd3,      1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd4242,   1'b0, NO_RES},
    '{ROW_CFG,  REG_MEDIAN_COUNT,   CMD_PUSH,  17'd1,      1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd9,      1'b0, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_CLEAR, 17'd0,      1'b1, NO_RES},
    '{ROW_ITEM, REG_FILTER_MODE,    CMD_PUSH,  17'd65536,  1'b1,
      '{17'd65536, 17'd65536, 17'd65536, 1'b0, 7'd1}}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [Q_W-1:0]         cfg_data = '0;

  clamped_median_ema_smoother dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of the block state and registers
  logic [Q_W-1:0]   hist [DEPTH];
  int               hist_fill;
  logic [Q_W-1:0]   ema_acc;
  bit               ema_seeded;
  logic [MODE_W-1:0] set_mode;
  logic [Q_W-1:0]   set_weight;
  logic [CNT_W-1:0] set_medlen;
  logic             set_clamp_en;
  logic [Q_W-1:0]   set_step;
  logic [CNT_W-1:0] set_minfill;

  smooth_res_t smooth_q [$];
  int          err_count = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] val);
    case (idx)
      REG_FILTER_MODE:    set_mode = val[MODE_W-1:0];
      REG_EMA_WEIGHT:     set_weight = val;
      REG_MEDIAN_COUNT:   set_medlen = val[CNT_W-1:0];
      REG_CLAMP_ENABLE:   set_clamp_en = val[0];
      REG_CLAMP_STEP:     set_step = val;
      REG_CLAMP_MIN_FILL: set_minfill = val[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic smooth_res_t smooth_predict(logic cmd, logic [Q_W-1:0] smp);
    smooth_res_t    r;
    logic [Q_W-1:0] s, prev, med;
    logic [Q_W-1:0] srt [DEPTH];
    logic [Q_W:0]   wide;
    logic [63:0]    wa, acc;
    int             len, i, j;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      for (i = 0; i < DEPTH; i++) hist[i] = '0;
      hist_fill = 0;
      ema_acc = '0;
      ema_seeded = 1'b0;
      return r;
    end
    s = (smp > ONE_Q) ? ONE_Q : smp;
    if (set_clamp_en && ema_seeded && hist_fill >= int'(set_minfill)) begin
      prev = hist[0];
      if (s >= prev && s - prev > set_step) begin
        r.clamped = 1'b1;
        wide = {1'b0, prev} + {1'b0, set_step};
        s = (wide > {1'b0, ONE_Q}) ? ONE_Q : wide[Q_W-1:0];
      end else if (s < prev && prev - s > set_step) begin
        r.clamped = 1'b1;
        s = (prev > set_step) ? prev - set_step : '0;
      end
    end else if (!ema_seeded) begin
      ema_acc = s;
    end
    for (i = DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = s;
    if (hist_fill < DEPTH) hist_fill++;

    len = (set_medlen == 0) ? 1 : int'(set_medlen);
    if (len > hist_fill) len = hist_fill;
    if (len < 2) begin
      med = hist[0];
    end else begin
      for (i = 0; i < len; i++) begin
        j = i;
        while (j > 0 && srt[j-1] > hist[i]) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = hist[i];
      end
      if (len % 2 == 1) begin
        med = srt[len/2];
      end else begin
        wide = ({1'b0, srt[len/2-1]} + {1'b0, srt[len/2]} + 18'd1) >> 1;
        med = wide[Q_W-1:0];
      end
    end

    if (set_mode == MODE_EMA_SAMPLE || set_mode == MODE_EMA_MEDIAN) begin
      wa = (set_weight > ONE_Q) ? 64'(ONE_Q) : 64'(set_weight);
      acc = wa * 64'(ema_acc) + (64'(ONE_Q) - wa)
            * 64'((set_mode == MODE_EMA_SAMPLE) ? s : med) + 64'(HALF_P);
      ema_acc = acc[FRAC_BITS +: Q_W];
      ema_seeded = 1'b1;
      r.filtered = ema_acc;
    end else begin
      r.filtered = s;
    end
    r.median = med;
    r.stored = s;
    r.fill = hist_fill[CNT_W-1:0];
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [Q_W-1:0] smp,
                           input logic typed, input smooth_res_t typed_res);
    smooth_res_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(smp);
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = smooth_predict(cmd, smp);
    smooth_q.push_back(typed ? typed_res : pred);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] val,
                           input bit more);
    in_tvalid <= 1'b0;
    while (smooth_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [Q_W-1:0] want,
                             input logic [Q_W-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    smooth_res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.filtered = out_tdata[FILT_LSB +: Q_W];
        got.median   = out_tdata[MED_LSB +: Q_W];
        got.stored   = out_tdata[STORED_LSB +: Q_W];
        got.fill     = out_tdata[FILL_LSB +: CNT_W];
        got.clamped  = out_tuser[0];
        if (smooth_q.size() == 0) begin
          err_count++;
          $display("%0t unexpected result: expected none, got filtered %0d median %0d",
                   $time, got.filtered, got.median);
        end else begin
          want = smooth_q.pop_front();
          check_field("filtered", want.filtered, got.filtered);
          check_field("median", want.median, got.median);
          check_field("stored_sample", want.stored, got.stored);
          check_field("was_clamped", Q_W'(want.clamped), Q_W'(got.clamped));
          check_field("fill_count", Q_W'(want.fill), Q_W'(got.fill));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t watchdog: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int             ph, n, r, span, level;
    logic [Q_W-1:0] smp;

    for (int i = 0; i < DEPTH; i++) hist[i] = '0;
    hist_fill    = 0;
    ema_acc      = '0;
    ema_seeded   = 1'b0;
    set_mode     = FILTER_MODE_RST;
    set_weight   = EMA_WEIGHT_RST;
    set_medlen   = MEDIAN_COUNT_RST;
    set_clamp_en = CLAMP_ENABLE_RST;
    set_step     = CLAMP_STEP_RST;
    set_minfill  = CLAMP_MIN_FILL_RST;
    level        = 32768;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 32;
    snk_idle_pct = 57;
    for (int k = 0; k < N_DIR; k++) begin
      if (DIR_TAB[k].kind == ROW_CFG)
        write_reg(DIR_TAB[k].reg_idx, DIR_TAB[k].value,
                  (k + 1 < N_DIR) && (DIR_TAB[(k + 1) % N_DIR].kind == ROW_CFG));
      else
        send_item(DIR_TAB[k].cmd, DIR_TAB[k].value, DIR_TAB[k].typed, DIR_TAB[k].res);
    end

    for (ph = 0; ph < N_PHASE; ph++) begin
      if (ph < 7) begin
        src_idle_pct = 32;
        snk_idle_pct = 57;
      end else if (ph < 14) begin
        src_idle_pct = 57;
        snk_idle_pct = 32;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end

      write_reg(REG_FILTER_MODE, Q_W'($urandom_range(0, 3)), 1'b1);
      case ($urandom_range(0, 3))
        0:       write_reg(REG_EMA_WEIGHT, Q_W'($urandom_range(0, 1) * 65536), 1'b1);
        1:       write_reg(REG_EMA_WEIGHT, Q_W'($urandom_range(0, 131071)), 1'b1);
        default: write_reg(REG_EMA_WEIGHT, Q_W'($urandom_range(0, 65536)), 1'b1);
      endcase
      // long windows are slow, keep them to a few phases
      if (ph % 6 == 5)
        write_reg(REG_MEDIAN_COUNT, Q_W'($urandom_range(0, 1) ? 64 : $urandom_range(64, 127)),
                  1'b1);
      else
        write_reg(REG_MEDIAN_COUNT, Q_W'($urandom_range(0, 8)), 1'b1);
      write_reg(REG_CLAMP_ENABLE, Q_W'($urandom_range(0, 3) != 0), 1'b1);
      case ($urandom_range(0, 4))
        0:       write_reg(REG_CLAMP_STEP, Q_W'(0), 1'b1);
        1:       write_reg(REG_CLAMP_STEP, Q_W'($urandom_range(0, 1) ? 65536 : 131071), 1'b1);
        2:       write_reg(REG_CLAMP_STEP, Q_W'($urandom_range(0, 131071)), 1'b1);
        default: write_reg(REG_CLAMP_STEP, Q_W'($urandom_range(1, 8000)), 1'b1);
      endcase
      case ($urandom_range(0, 4))
        0:       write_reg(REG_CLAMP_MIN_FILL, Q_W'(0), 1'b0);
        1:       write_reg(REG_CLAMP_MIN_FILL, Q_W'(64), 1'b0);
        2:       write_reg(REG_CLAMP_MIN_FILL, Q_W'($urandom_range(65, 127)), 1'b0);
        default: write_reg(REG_CLAMP_MIN_FILL, Q_W'($urandom_range(0, 20)), 1'b0);
      endcase

      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_item(CMD_CLEAR, Q_W'($urandom_range(0, 131071)), 1'b0, NO_RES);
        end else begin
          if (r < 9) begin
            smp = Q_W'($urandom_range(0, 131071));
          end else if (r < 18) begin
            smp = Q_W'($urandom_range(0, 65536));
          end else begin
            // random walk, mostly small steps so clamping sees both sides
            case ($urandom_range(0, 2))
              0:       span = 200;
              1:       span = 3000;
              default: span = 12000;
            endcase
            level = level + int'($urandom_range(0, 2 * span)) - span;
            if (level < 0) level = 0;
            if (level > 65536) level = 65536;
            smp = Q_W'(level);
          end
          send_item(CMD_PUSH, smp, 1'b0, NO_RES);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (smooth_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
